[sv/ccgr_pkg.sv]
// Package for the conserved column gap run block.
// Holds the letter table, field widths, the item and result records and the
// record that carries pushes from the column unit to the result queue.
package ccgr_pkg;

  localparam int LETTERS     = 20;
  localparam int COUNT_W     = 11;
  localparam int NSEQ_W      = 11;
  localparam int GAP_W       = 17;
  localparam int PROD_W      = 15;
  localparam int RESIDUE_W   = 8;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;
  localparam int FIFO_CW     = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [GAP_W-1:0]   GAP_MAX   = 17'd65536;
  localparam logic [NSEQ_W-1:0]  NSEQ_RESET = 11'd1;

  localparam logic KIND_VERDICT  = 1'b0;
  localparam logic KIND_TRAILING = 1'b1;

  // ASCII codes of the counted letters, upper case only
  localparam logic [RESIDUE_W-1:0] LETTER_CODE [LETTERS] = '{
    8'h41, 8'h47, 8'h50, 8'h4B, 8'h4C, 8'h56, 8'h49, 8'h4E, 8'h4D, 8'h45,
    8'h44, 8'h46, 8'h43, 8'h54, 8'h52, 8'h53, 8'h59, 8'h57, 8'h51, 8'h48
  };

  typedef struct packed {
    logic [RESIDUE_W-1:0] residue;
    logic                 column_end;
    logic                 alignment_end;
  } item_t;

  typedef struct packed {
    logic             kind;
    logic             conserved;
    logic [GAP_W-1:0] run_length;
    logic             last;
  } result_t;

  // Up to two results from one item; second only valid with first
  typedef struct packed {
    logic    vld0;
    logic    vld1;
    result_t res0;
    result_t res1;
  } push_t;

  // One-hot letter match of a residue; all zero for any other byte
  function automatic logic [LETTERS-1:0] letter_hit(input logic [RESIDUE_W-1:0] residue);
    logic [LETTERS-1:0] hit;
    hit = '0;
    for (int k = 0; k < LETTERS; k++) begin
      hit[k] = (residue == LETTER_CODE[k]);
    end
    return hit;
  endfunction

endpackage

[sv/ccgr_column.sv]
// Column unit: per-letter counters, conserved test and gap counter.
// Depends on ccgr_pkg. Turns one registered residue into up to two results.
module ccgr_column (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_vld,
  input  ccgr_pkg::item_t              item,
  input  logic [ccgr_pkg::NSEQ_W-1:0]  num_seq,
  output ccgr_pkg::push_t              push
);

  logic [ccgr_pkg::COUNT_W-1:0] counts_r   [ccgr_pkg::LETTERS];
  logic [ccgr_pkg::COUNT_W-1:0] counts_nxt [ccgr_pkg::LETTERS];
  logic [ccgr_pkg::GAP_W-1:0]   gap_r, gap_nxt;
  logic [ccgr_pkg::LETTERS-1:0] hit;
  logic [ccgr_pkg::LETTERS-1:0] meets;
  logic [ccgr_pkg::PROD_W-1:0]  need;
  logic [ccgr_pkg::COUNT_W-1:0] cnt_inc    [ccgr_pkg::LETTERS];
  logic [ccgr_pkg::GAP_W-1:0]   gap_after;
  logic                         cons;

  assign hit = ccgr_pkg::letter_hit(item.residue);

  // 9 * num_sequences as a shift and add
  assign need = ({4'b0, num_seq} << 3) + {4'b0, num_seq};

  // Count the residue with saturation and test each letter against the threshold
  always_comb begin
    for (int k = 0; k < ccgr_pkg::LETTERS; k++) begin
      if (item_vld && hit[k] && (counts_r[k] != ccgr_pkg::COUNT_MAX)) begin
        cnt_inc[k] = counts_r[k] + ccgr_pkg::COUNT_W'(1);
      end else begin
        cnt_inc[k] = counts_r[k];
      end
      meets[k] = (cnt_inc[k] != '0) &&
                 ((({4'b0, cnt_inc[k]} << 3) + ({4'b0, cnt_inc[k]} << 1)) >= need);
    end
  end

  assign cons = |meets;

  // Advance gap and counters; build the results of a column end
  always_comb begin
    gap_after = gap_r;
    gap_nxt   = gap_r;
    push      = '0;
    for (int k = 0; k < ccgr_pkg::LETTERS; k++) begin
      counts_nxt[k] = cnt_inc[k];
    end
    if (item_vld && item.column_end) begin
      for (int k = 0; k < ccgr_pkg::LETTERS; k++) begin
        counts_nxt[k] = '0;
      end
      push.vld0            = 1'b1;
      push.res0.kind       = ccgr_pkg::KIND_VERDICT;
      push.res0.conserved  = cons;
      push.res0.last       = !item.alignment_end;
      if (cons) begin
        push.res0.run_length = gap_r + ccgr_pkg::GAP_W'(1);
        gap_after            = '0;
      end else begin
        push.res0.run_length = '0;
        if (gap_r < ccgr_pkg::GAP_MAX) begin
          gap_after = gap_r + ccgr_pkg::GAP_W'(1);
        end
      end
      gap_nxt = gap_after;
      if (item.alignment_end) begin
        push.vld1            = 1'b1;
        push.res1.kind       = ccgr_pkg::KIND_TRAILING;
        push.res1.conserved  = 1'b0;
        push.res1.run_length = gap_after;
        push.res1.last       = 1'b1;
        gap_nxt              = '0;
      end
    end
  end

  // Hold counters and gap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= '0;
      for (int k = 0; k < ccgr_pkg::LETTERS; k++) begin
        counts_r[k] <= '0;
      end
    end else begin
      gap_r <= gap_nxt;
      for (int k = 0; k < ccgr_pkg::LETTERS; k++) begin
        counts_r[k] <= counts_nxt[k];
      end
    end
  end

endmodule

[sv/ccgr_out_fifo.sv]
// Result queue: four entries, takes up to two results a cycle, gives one.
// Depends on ccgr_pkg for the result and push records.
module ccgr_out_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ccgr_pkg::push_t               push,
  input  logic                          pop,
  output ccgr_pkg::result_t             head,
  output logic                          head_vld,
  output logic [ccgr_pkg::FIFO_CW-1:0]  count
);

  ccgr_pkg::result_t               mem [ccgr_pkg::FIFO_DEPTH];
  logic [ccgr_pkg::FIFO_AW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [ccgr_pkg::FIFO_CW-1:0]    count_r, count_nxt;
  logic [ccgr_pkg::FIFO_CW-1:0]    n_push;
  logic                            do_pop;

  assign do_pop   = pop && (count_r != '0);
  assign n_push   = push.vld1 ? ccgr_pkg::FIFO_CW'(2) :
                    (push.vld0 ? ccgr_pkg::FIFO_CW'(1) : '0);
  assign wr_nxt   = wr_r + n_push[ccgr_pkg::FIFO_AW-1:0];
  assign rd_nxt   = rd_r + ccgr_pkg::FIFO_AW'(do_pop);
  assign count_nxt = count_r + n_push - ccgr_pkg::FIFO_CW'(do_pop);

  assign head     = mem[rd_r];
  assign head_vld = (count_r != '0);
  assign count    = count_r;

  // Store results
  always_ff @(posedge clk) begin
    if (push.vld0) begin
      mem[wr_r] <= push.res0;
    end
    if (push.vld1) begin
      mem[wr_r + ccgr_pkg::FIFO_AW'(1)] <= push.res1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

[sv/conserved_column_gap_runs.sv]
// Top level of the conserved column gap run block.
// Depends on ccgr_pkg, ccgr_column and ccgr_out_fifo.
//
// Usage:
//   Residues arrive on the in_ channel, one per transfer, column by column;
//   in_column_end marks the last residue of a column and in_alignment_end
//   the last column. Each column end gives a verdict result; the last column
//   also gives the trailing gap run. Results leave on the out_ channel.
//   cfg_wr_en / cfg_wr_data write num_sequences (reset value 1) while idle.
// Path: a transferred residue is registered in the staging register and is
//   counted and tested in the next cycle; its results are then written into
//   the result queue, from which the out_ channel transfers them.
// Throughput: one residue per cycle while in_stall is low. An item with
//   two results needs two output transfers; the four-entry result queue
//   raises in_stall when it could not take two more from the next item.
// Reset (rst_n low, synchronous): counters, gap, staging register and queue
//   clear; out_valid drops in the following cycle.
// Receiver stall: results wait in the queue, the head holds still; once
//   two more results do not fit, in_stall rises and input transfers stop.
module conserved_column_gap_runs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ccgr_pkg::RESIDUE_W-1:0]       in_residue,
  input  logic                                 in_column_end,
  input  logic                                 in_alignment_end,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_kind,
  output logic                                 out_conserved,
  output logic [ccgr_pkg::GAP_W-1:0]           out_run_length,
  output logic                                 out_last,
  input  logic                                 cfg_wr_en,
  input  logic [ccgr_pkg::NSEQ_W-1:0]          cfg_wr_data
);

  logic [ccgr_pkg::NSEQ_W-1:0]   num_seq_r;
  ccgr_pkg::item_t               item_r;
  logic                          item_vld_r;
  ccgr_pkg::push_t               push;
  ccgr_pkg::result_t             head;
  logic                          head_vld;
  logic [ccgr_pkg::FIFO_CW-1:0]  fifo_count;
  logic [ccgr_pkg::FIFO_CW:0]    pending;
  logic                          in_xfer;

  // Results in the queue plus those the staged item is about to push
  assign pending  = {1'b0, fifo_count} + (push.vld1 ? (ccgr_pkg::FIFO_CW+1)'(2) :
                    (push.vld0 ? (ccgr_pkg::FIFO_CW+1)'(1) : '0));
  assign in_stall = (pending + (ccgr_pkg::FIFO_CW+1)'(2)) >
                    (ccgr_pkg::FIFO_CW+1)'(ccgr_pkg::FIFO_DEPTH);
  assign in_xfer  = in_valid && !in_stall;

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_seq_r <= ccgr_pkg::NSEQ_RESET;
    end else if (cfg_wr_en) begin
      num_seq_r <= cfg_wr_data;
    end
  end

  // Stage the input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.residue       <= in_residue;
      item_r.column_end    <= in_column_end;
      item_r.alignment_end <= in_alignment_end;
    end
  end

  ccgr_column u_column (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (item_vld_r),
    .item     (item_r),
    .num_seq  (num_seq_r),
    .push     (push)
  );

  ccgr_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (!out_stall),
    .head     (head),
    .head_vld (head_vld),
    .count    (fifo_count)
  );

  assign out_valid      = head_vld;
  assign out_kind       = head.kind;
  assign out_conserved  = head.conserved;
  assign out_run_length = head.run_length;
  assign out_last       = head.last;

endmodule

[sv/ccgr_checker.sv]
// Port checker for the conserved column gap run block, bound to the top level.
// Depends on ccgr_pkg for the field widths and result kind codes.
module ccgr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_kind,
  input logic                           out_conserved,
  input logic [ccgr_pkg::GAP_W-1:0]     out_run_length,
  input logic                           out_last
);

  // Queue empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Stalled result stays offered
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Stalled result payload holds
  a_stall_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_kind) && $stable(out_conserved) &&
                               $stable(out_run_length) && $stable(out_last))
    else $error("result changed while stalled");

  // Trailing run closes its item and is never conserved
  a_trailing_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == ccgr_pkg::KIND_TRAILING) |-> out_last && !out_conserved)
    else $error("malformed trailing run");

  // Verdict of a column that is not conserved carries no run
  a_gap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == ccgr_pkg::KIND_VERDICT) && !out_conserved
    |-> out_run_length == '0)
    else $error("run length on a column that is not conserved");

endmodule

bind conserved_column_gap_runs ccgr_checker u_ccgr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_kind       (out_kind),
  .out_conserved  (out_conserved),
  .out_run_length (out_run_length),
  .out_last       (out_last)
);

[dv/tb_top.sv]
// Testbench for conserved_column_gap_runs: feeds residues column by column,
// predicts column verdicts and trailing gap runs in a scoreboard class and checks them.
// Depends on ccgr_pkg and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         SETTLE_CYCLES    = 6;
  localparam int         LONG_HOLD_CYCLES = 80;
  localparam int         RANDOM_ITEMS     = 320;
  localparam int         RANDOM_VERDICTS  = 60;
  localparam logic [7:0] DASH             = 8'h2D;

  // Column state model plus the queue of results still owed by the block
  class gap_run_scoreboard;
    logic [ccgr_pkg::NSEQ_W-1:0]  nseq;
    logic [ccgr_pkg::COUNT_W-1:0] tally [ccgr_pkg::LETTERS];
    logic [ccgr_pkg::GAP_W-1:0]   gap;
    ccgr_pkg::result_t            due_runs [$];
    int                           errors;
    int                           verdicts_seen;

    function new();
      nseq = ccgr_pkg::NSEQ_RESET;
      gap = '0;
      foreach (tally[k]) tally[k] = '0;
      errors = 0;
      verdicts_seen = 0;
    endfunction

    static function logic [7:0] letter_at(int k);
      logic [8*ccgr_pkg::LETTERS-1:0] codes;
      codes = "AGPKLVINMEDFCTRSYWQH";
      return codes[8*(ccgr_pkg::LETTERS-1-k) +: 8];
    endfunction

    function void set_nseq(logic [ccgr_pkg::NSEQ_W-1:0] value);
      nseq = value;
    endfunction

    // Count the residue; on a column end decide and queue the results
    function void note_item(ccgr_pkg::item_t it);
      int unsigned       need;
      bit                cons;
      ccgr_pkg::result_t r;
      for (int k = 0; k < ccgr_pkg::LETTERS; k++) begin
        if (it.residue == letter_at(k) && tally[k] != ccgr_pkg::COUNT_MAX) tally[k]++;
      end
      if (!it.column_end) return;
      need = 9 * int'(nseq);
      cons = 1'b0;
      foreach (tally[k]) begin
        if (tally[k] != 0 && 10 * int'(tally[k]) >= need) cons = 1'b1;
      end
      foreach (tally[k]) tally[k] = '0;
      r.kind = ccgr_pkg::KIND_VERDICT;
      r.conserved = cons;
      r.last = !it.alignment_end;
      if (cons) begin
        r.run_length = gap + 17'd1;
        gap = '0;
      end else begin
        r.run_length = '0;
        if (gap != ccgr_pkg::GAP_MAX) gap++;
      end
      due_runs.push_back(r);
      // Last column also reports the trailing gap
      if (it.alignment_end) begin
        r.kind = ccgr_pkg::KIND_TRAILING;
        r.conserved = 1'b0;
        r.run_length = gap;
        r.last = 1'b1;
        due_runs.push_back(r);
        gap = '0;
      end
    endfunction

    function void check_result(ccgr_pkg::result_t got);
      ccgr_pkg::result_t want;
      if (due_runs.size() == 0) begin
        $error("result with nothing expected: kind %0d run_length %0d",
               got.kind, got.run_length);
        errors++;
        return;
      end
      want = due_runs.pop_front();
      if (want.kind == ccgr_pkg::KIND_VERDICT) verdicts_seen++;
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.conserved !== want.conserved) begin
        $error("conserved: expected %0d, actual %0d", want.conserved, got.conserved);
        errors++;
      end
      if (got.run_length !== want.run_length) begin
        $error("run_length: expected %0d, actual %0d", want.run_length, got.run_length);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                           clk              = 1'b0;
  logic                           rst_n            = 1'b0;
  logic                           in_valid         = 1'b0;
  logic                           in_stall;
  logic [ccgr_pkg::RESIDUE_W-1:0] in_residue       = '0;
  logic                           in_column_end    = 1'b0;
  logic                           in_alignment_end = 1'b0;
  logic                           out_valid;
  logic                           out_stall        = 1'b0;
  logic                           out_kind;
  logic                           out_conserved;
  logic [ccgr_pkg::GAP_W-1:0]     out_run_length;
  logic                           out_last;
  logic                           cfg_wr_en        = 1'b0;
  logic [ccgr_pkg::NSEQ_W-1:0]    cfg_wr_data      = '0;

  gap_run_scoreboard runs_sb = new();
  bit                send_idle_on = 1'b1;
  bit                recv_idle_on = 1'b1;
  bit                hold_request = 1'b0;
  int unsigned       items_sent = 0;

  always #1 clk = ~clk;

  conserved_column_gap_runs uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_residue       (in_residue),
    .in_column_end    (in_column_end),
    .in_alignment_end (in_alignment_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_conserved    (out_conserved),
    .out_run_length   (out_run_length),
    .out_last         (out_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  // Mostly short bursts, now and then a long one
  function automatic int unsigned burst_len();
    return ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
  endfunction

  // Counted letters, lower case letters, or any byte at all
  function automatic logic [7:0] noise_residue();
    logic [7:0] r;
    case ($urandom_range(3))
      0, 1:    r = gap_run_scoreboard::letter_at($urandom_range(ccgr_pkg::LETTERS - 1));
      2:       r = gap_run_scoreboard::letter_at($urandom_range(ccgr_pkg::LETTERS - 1)) | 8'h20;
      default: r = 8'($urandom_range(255));
    endcase
    return r;
  endfunction

  // Offer one residue and hold it until the transfer
  task automatic send_item(input logic [7:0] residue, input logic col_end,
                           input logic aln_end);
    int unsigned     idle;
    ccgr_pkg::item_t it;
    it.residue = residue;
    it.column_end = col_end;
    it.alignment_end = aln_end;
    idle = (send_idle_on && $urandom_range(2) == 0) ? burst_len() : 0;
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_residue <= residue;
    in_column_end <= col_end;
    in_alignment_end <= aln_end;
    do @(posedge clk); while (in_stall !== 1'b0);
    runs_sb.note_item(it);
    items_sent++;
  endtask

  // Stop offering until every owed result has come out, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (runs_sb.due_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_nseq(input logic [ccgr_pkg::NSEQ_W-1:0] value);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    runs_sb.set_nseq(value);
  endtask

  // Column of hits copies of lead followed by dashes
  task automatic send_split(input logic [7:0] lead, input int unsigned hits,
                            input int unsigned total, input logic closes);
    for (int unsigned i = 0; i < total; i++) begin
      send_item((i < hits) ? lead : DASH, i == total - 1, (i == total - 1) && closes);
    end
  endtask

  // Column with a dominant letter at the given purity, stray alignment ends inside
  task automatic send_column(input int unsigned len, input logic [7:0] lead,
                             input int unsigned purity, input logic closes);
    logic [7:0] r;
    for (int unsigned i = 0; i < len; i++) begin
      r = ($urandom_range(99) < purity) ? lead : noise_residue();
      if (i == len - 1) send_item(r, 1'b1, closes);
      else send_item(r, 1'b0, $urandom_range(15) == 0);
    end
  endtask

  // Result side: check each transfer, then pick the next stall value
  initial begin : result_sink
    int unsigned       hold_cycles;
    int unsigned       stall_cycles;
    ccgr_pkg::result_t got;
    hold_cycles = 0;
    stall_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        got.kind = out_kind;
        got.conserved = out_conserved;
        got.run_length = out_run_length;
        got.last = out_last;
        runs_sb.check_result(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_cycles = LONG_HOLD_CYCLES;
      end
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (stall_cycles != 0) begin
        out_stall <= 1'b1;
        stall_cycles--;
      end else if (recv_idle_on && $urandom_range(3) == 0) begin
        stall_cycles = burst_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Main sequence
  initial begin : stimulus
    int unsigned                 phase;
    int unsigned                 cols;
    int                          len;
    int unsigned                 purity;
    int unsigned                 rand_start;
    int                          verdict_start;
    logic [ccgr_pkg::NSEQ_W-1:0] nseq_now;
    logic [7:0]                  lead;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting: one residue per column but one column of two
    send_item("A", 1'b1, 1'b0);
    send_item(DASH, 1'b1, 1'b0);
    send_item("a", 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item("H", 1'b1, 1'b0);
    send_item("Q", 1'b0, 1'b1);
    send_item("Q", 1'b1, 1'b0);
    send_item("W", 1'b1, 1'b1);
    send_item("*", 1'b1, 1'b1);
    for (int k = 0; k < ccgr_pkg::LETTERS; k++) begin
      send_item(gap_run_scoreboard::letter_at(k), 1'b1, k == ccgr_pkg::LETTERS - 1);
    end

    // Ninety percent boundary and an overfull column
    write_nseq(11'd10);
    send_split("V", 9, 10, 1'b0);
    send_split("E", 8, 10, 1'b0);
    send_split("E", 11, 11, 1'b1);

    // Zero sequences: any letter conserves, an empty column never does
    write_nseq(11'd0);
    send_split("C", 0, 1, 1'b0);
    send_split("C", 1, 1, 1'b0);
    send_split("T", 0, 3, 1'b1);

    // Random alignments over a range of column heights
    rand_start = items_sent;
    verdict_start = runs_sb.verdicts_seen;
    phase = 0;
    while (items_sent - rand_start < RANDOM_ITEMS ||
           runs_sb.verdicts_seen - verdict_start < RANDOM_VERDICTS) begin
      case (phase)
        0:       nseq_now = 11'd1;
        1:       nseq_now = 11'd3;
        2:       nseq_now = 11'd0;
        3:       nseq_now = 11'd5;
        4:       nseq_now = 11'd10;
        5:       nseq_now = 11'd2;
        default: nseq_now = ccgr_pkg::NSEQ_W'($urandom_range(12));
      endcase
      write_nseq(nseq_now);
      send_idle_on = $urandom_range(3) != 0;
      recv_idle_on = $urandom_range(3) != 0;
      // Hold the result side off while residues keep coming
      if (phase == 1) begin
        send_idle_on = 1'b0;
        hold_request = 1'b1;
      end
      repeat (2) begin
        cols = $urandom_range(6, 1);
        for (int unsigned c = 0; c < cols; c++) begin
          if (nseq_now == 0) len = $urandom_range(4, 1);
          else if ($urandom_range(4) == 0) len = int'(nseq_now) + int'($urandom_range(2)) - 1;
          else len = nseq_now;
          if (len < 1) len = 1;
          case ($urandom_range(4))
            0:       purity = 100;
            1:       purity = 95;
            2:       purity = 90;
            3:       purity = 75;
            default: purity = $urandom_range(100);
          endcase
          lead = gap_run_scoreboard::letter_at($urandom_range(ccgr_pkg::LETTERS - 1));
          send_column(len, lead, purity, c == cols - 1);
        end
        if (phase != 1 && $urandom_range(3) == 0) wait_drained();
      end
      phase++;
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;

    wait_drained();
    if (runs_sb.errors == 0 && runs_sb.due_runs.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
sv/ccgr_pkg.sv
sv/ccgr_column.sv
sv/ccgr_out_fifo.sv
sv/conserved_column_gap_runs.sv
sv/ccgr_checker.sv
dv/tb_top.sv
